### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RMIS_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define RMIS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/rmis_pkg.sv
// ----------------------------------------------------------------------------
// rmis_pkg
// Types, opcodes, status codes and cost constants of the instruction step.
// ----------------------------------------------------------------------------
`default_nettype none

package rmis_pkg;

   localparam int NUM_REGS     = 8;
   localparam int REG_IDX_BITS = 3;
   localparam int PLEN_BITS    = 17;
   localparam int COST_BITS    = 63;
   localparam int CSR_ADDR_BITS = 3;

   typedef logic [63:0]           word_type;
   typedef logic [4:0]            cmd_type;
   typedef logic [2:0]            status_type;
   typedef logic [6:0]            cost_inc_type;
   typedef logic [PLEN_BITS-1:0]  plen_type;

   localparam cmd_type OP_HALT   = 5'd0;
   localparam cmd_type OP_READ   = 5'd1;
   localparam cmd_type OP_WRITE  = 5'd2;
   localparam cmd_type OP_LOAD   = 5'd3;
   localparam cmd_type OP_STORE  = 5'd4;
   localparam cmd_type OP_RLOAD  = 5'd5;
   localparam cmd_type OP_RSTORE = 5'd6;
   localparam cmd_type OP_ADD    = 5'd7;
   localparam cmd_type OP_SUB    = 5'd8;
   localparam cmd_type OP_SWAP   = 5'd9;
   localparam cmd_type OP_RST    = 5'd10;
   localparam cmd_type OP_INC    = 5'd11;
   localparam cmd_type OP_DEC    = 5'd12;
   localparam cmd_type OP_SHL    = 5'd13;
   localparam cmd_type OP_SHR    = 5'd14;
   localparam cmd_type OP_JUMP   = 5'd15;
   localparam cmd_type OP_JPOS   = 5'd16;
   localparam cmd_type OP_JZERO  = 5'd17;
   localparam cmd_type OP_CALL   = 5'd18;
   localparam cmd_type OP_RET    = 5'd19;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_HALTED   = 3'd1;
   localparam status_type ST_BAD_PC   = 3'd2;
   localparam status_type ST_NO_INPUT = 3'd3;
   localparam status_type ST_BAD_ADDR = 3'd4;
   localparam status_type ST_BAD_OP   = 3'd5;

   localparam cost_inc_type COST_IO   = 7'd100;
   localparam cost_inc_type COST_MEM  = 7'd50;
   localparam cost_inc_type COST_ALU  = 7'd5;
   localparam cost_inc_type COST_BASE = 7'd1;

   localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

   localparam plen_type PLEN_RESET = 17'h10000;

   localparam logic CSR_IDX_PROGRAM_LENGTH = 1'b0;

   typedef struct packed {
      cmd_type            cmd;
      logic [31:0]        operand;
      logic signed [63:0] read_value;
      logic               read_available;
   } req_type;

   typedef struct packed {
      logic [15:0]          next_pc;
      logic signed [63:0]   accumulator;
      logic [COST_BITS-1:0] total_cost;
      status_type           status;
   } rsp_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [REG_IDX_BITS-1:0] x;
      status_type              status;
   } ctl_type;

endpackage

`default_nettype wire

### hw/rtl/rmis_dmem.sv
// ----------------------------------------------------------------------------
// rmis_dmem
// Data memory: one write port, one registered read port, clearing pass
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rmis_dmem #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   output logic                         busy,
   input  wire                          rd_en,
   input  wire [MEM_ADDR_BITS-1:0]      rd_addr,
   output rmis_pkg::word_type           rd_data,
   input  wire                          wr_en,
   input  wire [MEM_ADDR_BITS-1:0]      wr_addr,
   input  rmis_pkg::word_type           wr_data
);

   localparam int MEM_WORDS = 1 << MEM_ADDR_BITS;

   rmis_pkg::word_type        mem [MEM_WORDS];
   rmis_pkg::word_type        rd_data_ff;
   logic                      clear_ff;
   logic                      clear_in;
   logic [MEM_ADDR_BITS-1:0]  clr_addr_ff;
   logic [MEM_ADDR_BITS-1:0]  clr_addr_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clear_in    = clear_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + MEM_ADDR_BITS'(1);
         if (clr_addr_ff == {MEM_ADDR_BITS{1'b1}}) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign busy    = clear_ff;
   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/rmis_issue.sv
// ----------------------------------------------------------------------------
// rmis_issue
// Issue stage: fault checks, next pc, memory address and read launch.
// ----------------------------------------------------------------------------
`default_nettype none

module rmis_issue #(
   parameter int MEM_ADDR_BITS = 16,
   parameter int PC_BITS       = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  rmis_pkg::req_type                  req_payload,
   input  wire                                mem_busy,
   input  wire [PC_BITS-1:0]                  pc,
   input  rmis_pkg::plen_type                 program_length,
   input  rmis_pkg::word_type                 rd_r0,
   input  rmis_pkg::word_type                 rd_rx,
   output logic [rmis_pkg::REG_IDX_BITS-1:0]  rd_idx,
   input  wire                                iss_done,
   output logic                               iss_valid,
   output rmis_pkg::ctl_type                  iss_ctl,
   output logic [MEM_ADDR_BITS-1:0]           iss_addr,
   output logic [PC_BITS-1:0]                 iss_npc,
   output rmis_pkg::word_type                 iss_read_value,
   output logic                               mem_rd_en,
   output logic [MEM_ADDR_BITS-1:0]           mem_rd_addr
);

   logic                       accept;
   logic                       iss_valid_ff;
   logic                       iss_valid_in;
   rmis_pkg::ctl_type          ctl_ff;
   rmis_pkg::ctl_type          ctl_in;
   logic [MEM_ADDR_BITS-1:0]   addr_ff;
   logic [MEM_ADDR_BITS-1:0]   addr_in;
   logic [PC_BITS-1:0]         npc_ff;
   rmis_pkg::word_type         read_value_ff;
   rmis_pkg::word_type         target;
   rmis_pkg::word_type         seq_pc;
   rmis_pkg::word_type         limit;
   rmis_pkg::cmd_type          cmd;
   logic [31:0]                operand;
   logic                       r0_pos;
   logic                       pc_bad;
   logic                       target_bad;
   logic                       is_direct;
   logic                       is_indirect;
   logic                       addr_bad;

   assign cmd     = req_payload.cmd;
   assign operand = req_payload.operand;
   assign rd_idx  = operand[rmis_pkg::REG_IDX_BITS-1:0];

   assign req_stall = iss_valid_ff | mem_busy;
   assign accept    = req_valid & ~req_stall;

   assign seq_pc = 64'(pc) + 64'd1;
   assign limit  = 64'(program_length);
   assign r0_pos = (rd_r0 != '0) && !rd_r0[63];

   always_comb begin
      unique case (cmd) inside
         rmis_pkg::OP_JUMP, rmis_pkg::OP_CALL: target = 64'(operand);
         rmis_pkg::OP_JPOS:  target = r0_pos ? 64'(operand) : seq_pc;
         rmis_pkg::OP_JZERO: target = (rd_r0 == '0) ? 64'(operand) : seq_pc;
         rmis_pkg::OP_RET:   target = rd_r0;
         default:            target = seq_pc;
      endcase
   end

   assign pc_bad      = 64'(pc) >= limit;
   assign target_bad  = (|target[63:PC_BITS]) || (target >= limit);
   assign is_direct   = (cmd == rmis_pkg::OP_LOAD) || (cmd == rmis_pkg::OP_STORE);
   assign is_indirect = (cmd == rmis_pkg::OP_RLOAD) || (cmd == rmis_pkg::OP_RSTORE);
   assign addr_bad    = (is_direct && (|operand[31:MEM_ADDR_BITS]))
                     || (is_indirect && (|rd_rx[63:MEM_ADDR_BITS]));
   assign addr_in     = is_indirect ? rd_rx[MEM_ADDR_BITS-1:0]
                                    : operand[MEM_ADDR_BITS-1:0];

   always_comb begin
      ctl_in.cmd = cmd;
      ctl_in.x   = rd_idx;
      if (pc_bad) begin
         ctl_in.status = rmis_pkg::ST_BAD_PC;
      end else if (cmd > rmis_pkg::OP_RET) begin
         ctl_in.status = rmis_pkg::ST_BAD_OP;
      end else if (cmd == rmis_pkg::OP_HALT) begin
         ctl_in.status = rmis_pkg::ST_HALTED;
      end else if ((cmd == rmis_pkg::OP_READ) && !req_payload.read_available) begin
         ctl_in.status = rmis_pkg::ST_NO_INPUT;
      end else if (addr_bad) begin
         ctl_in.status = rmis_pkg::ST_BAD_ADDR;
      end else if (target_bad) begin
         ctl_in.status = rmis_pkg::ST_BAD_PC;
      end else begin
         ctl_in.status = rmis_pkg::ST_OK;
      end
   end

   always_comb begin
      iss_valid_in = iss_valid_ff;
      if (accept) begin
         iss_valid_in = 1'b1;
      end else if (iss_done) begin
         iss_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
      end else begin
         iss_valid_ff <= iss_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff        <= ctl_in;
         addr_ff       <= addr_in;
         npc_ff        <= target[PC_BITS-1:0];
         read_value_ff <= req_payload.read_value;
      end
   end

   assign iss_valid      = iss_valid_ff;
   assign iss_ctl        = ctl_ff;
   assign iss_addr       = addr_ff;
   assign iss_npc        = npc_ff;
   assign iss_read_value = read_value_ff;
   assign mem_rd_en      = accept;
   assign mem_rd_addr    = addr_in;

endmodule

`default_nettype wire

### hw/rtl/rmis_exec.sv
// ----------------------------------------------------------------------------
// rmis_exec
// Execute stage: register file, pc, cost counter, write-back and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmis_exec #(
   parameter int MEM_ADDR_BITS = 16,
   parameter int PC_BITS       = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                iss_valid,
   input  rmis_pkg::ctl_type                  iss_ctl,
   input  wire [MEM_ADDR_BITS-1:0]            iss_addr,
   input  wire [PC_BITS-1:0]                  iss_npc,
   input  rmis_pkg::word_type                 iss_read_value,
   output logic                               iss_done,
   input  rmis_pkg::word_type                 mem_rd_data,
   output logic                               mem_wr_en,
   output logic [MEM_ADDR_BITS-1:0]           mem_wr_addr,
   output rmis_pkg::word_type                 mem_wr_data,
   input  wire [rmis_pkg::REG_IDX_BITS-1:0]   rd_idx,
   output rmis_pkg::word_type                 rd_r0,
   output rmis_pkg::word_type                 rd_rx,
   output logic [PC_BITS-1:0]                 pc,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output rmis_pkg::rsp_type                  rsp_payload
);

   rmis_pkg::word_type                  regs_ff [rmis_pkg::NUM_REGS];
   rmis_pkg::word_type                  regs_in [rmis_pkg::NUM_REGS];
   logic [PC_BITS-1:0]                  pc_ff;
   logic [PC_BITS-1:0]                  pc_in;
   logic [rmis_pkg::COST_BITS-1:0]      cost_ff;
   logic [rmis_pkg::COST_BITS-1:0]      cost_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   rmis_pkg::rsp_type                   rsp_payload_ff;
   rmis_pkg::rsp_type                   rsp_payload_in;
   logic                                fire;
   logic                                commit;
   rmis_pkg::word_type                  r0;
   rmis_pkg::word_type                  rx;
   logic                                x_wr;
   rmis_pkg::word_type                  x_val;
   logic                                r0_wr;
   rmis_pkg::word_type                  r0_val;
   logic                                mem_wr;
   rmis_pkg::cost_inc_type              cost_inc;
   rmis_pkg::word_type                  cost_sum;

   assign fire   = iss_valid & (~rsp_valid_ff | ~rsp_stall);
   assign commit = fire && (iss_ctl.status == rmis_pkg::ST_OK);
   assign r0     = regs_ff[0];
   assign rx     = regs_ff[iss_ctl.x];

   always_comb begin
      x_wr     = 1'b0;
      x_val    = rx;
      r0_wr    = 1'b0;
      r0_val   = r0;
      mem_wr   = 1'b0;
      cost_inc = rmis_pkg::COST_BASE;
      unique case (iss_ctl.cmd) inside
         rmis_pkg::OP_READ: begin
            r0_wr    = 1'b1;
            r0_val   = iss_read_value;
            cost_inc = rmis_pkg::COST_IO;
         end
         rmis_pkg::OP_WRITE: begin
            cost_inc = rmis_pkg::COST_IO;
         end
         rmis_pkg::OP_LOAD, rmis_pkg::OP_RLOAD: begin
            r0_wr    = 1'b1;
            r0_val   = mem_rd_data;
            cost_inc = rmis_pkg::COST_MEM;
         end
         rmis_pkg::OP_STORE, rmis_pkg::OP_RSTORE: begin
            mem_wr   = 1'b1;
            cost_inc = rmis_pkg::COST_MEM;
         end
         rmis_pkg::OP_ADD: begin
            r0_wr    = 1'b1;
            r0_val   = r0 + rx;
            cost_inc = rmis_pkg::COST_ALU;
         end
         rmis_pkg::OP_SUB: begin
            r0_wr    = 1'b1;
            r0_val   = ($signed(r0) >= $signed(rx)) ? (r0 - rx) : '0;
            cost_inc = rmis_pkg::COST_ALU;
         end
         rmis_pkg::OP_SWAP: begin
            x_wr     = 1'b1;
            x_val    = r0;
            r0_wr    = 1'b1;
            r0_val   = rx;
            cost_inc = rmis_pkg::COST_ALU;
         end
         rmis_pkg::OP_RST: begin
            x_wr  = 1'b1;
            x_val = '0;
         end
         rmis_pkg::OP_INC: begin
            x_wr  = 1'b1;
            x_val = rx + 64'd1;
         end
         rmis_pkg::OP_DEC: begin
            x_wr  = 1'b1;
            x_val = ((rx != '0) && !rx[63]) ? (rx - 64'd1) : rx;
         end
         rmis_pkg::OP_SHL: begin
            x_wr  = 1'b1;
            x_val = {rx[62:0], 1'b0};
         end
         rmis_pkg::OP_SHR: begin
            x_wr  = 1'b1;
            x_val = {rx[63], rx[63:1]};
         end
         rmis_pkg::OP_CALL: begin
            r0_wr  = 1'b1;
            r0_val = 64'(pc_ff) + 64'd1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < rmis_pkg::NUM_REGS; i++) begin
         regs_in[i] = regs_ff[i];
         if (commit && x_wr && (iss_ctl.x == rmis_pkg::REG_IDX_BITS'(i))) begin
            regs_in[i] = x_val;
         end
      end
      if (commit && r0_wr) begin
         regs_in[0] = r0_val;
      end
   end

   assign cost_sum = {1'b0, cost_ff} + 64'(cost_inc);

   always_comb begin
      pc_in   = pc_ff;
      cost_in = cost_ff;
      if (commit) begin
         pc_in   = iss_npc;
         cost_in = cost_sum[63] ? rmis_pkg::COST_MAX : cost_sum[rmis_pkg::COST_BITS-1:0];
      end
   end

   always_comb begin
      rsp_payload_in.next_pc     = 16'(pc_in);
      rsp_payload_in.accumulator = regs_in[0];
      rsp_payload_in.total_cost  = cost_in;
      rsp_payload_in.status      = iss_ctl.status;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rmis_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
         pc_ff        <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         regs_ff      <= regs_in;
         pc_ff        <= pc_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign iss_done    = fire;
   assign mem_wr_en   = commit & mem_wr;
   assign mem_wr_addr = iss_addr;
   assign mem_wr_data = r0;
   assign rd_r0       = regs_ff[0];
   assign rd_rx       = regs_ff[rd_idx];
   assign pc          = pc_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

### hw/rtl/register_machine_instruction_step.sv
// ----------------------------------------------------------------------------
// register_machine_instruction_step
// Executes one accumulator-machine instruction per request transaction.
//
// The host fetches the instruction at the pc reported in the last response
// and sends it on the req channel (opcode, operand, pending input value).
// Each request yields exactly one response: next pc, accumulator, total cost
// and a status code. program_length is set through the csr port at byte
// address 0 and may only change while no request is in flight.
//
// An accepted request is registered in the issue stage; the execute stage
// then registers its response once the output register is empty or not stalled.
// The issue stage holds one instruction until it has written back, since
// the next one reads the register file and data memory on acceptance.
// Reset: registers, pc and cost clear at once; then the data memory is
// cleared one word per cycle, all 2**MEM_ADDR_BITS words (65536 by default),
// with req_stall high throughout.
// rsp_stall holds the response in its output register; one more request
// is still taken, then req_stall stays high until the response drains.
// ----------------------------------------------------------------------------
`default_nettype none

module register_machine_instruction_step #(
   parameter int MEM_ADDR_BITS = 16,
   parameter int PC_BITS       = 16
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  rmis_pkg::req_type                    req_payload,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output rmis_pkg::rsp_type                    rsp_payload,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire [rmis_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire [31:0]                           csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   rmis_pkg::plen_type                    plen_ff;
   rmis_pkg::plen_type                    plen_in;
   logic                                  csr_hit;
   logic                                  mem_busy;
   logic [PC_BITS-1:0]                    pc;
   rmis_pkg::word_type                    rd_r0;
   rmis_pkg::word_type                    rd_rx;
   logic [rmis_pkg::REG_IDX_BITS-1:0]     rd_idx;
   logic                                  iss_done;
   logic                                  iss_valid;
   rmis_pkg::ctl_type                     iss_ctl;
   logic [MEM_ADDR_BITS-1:0]              iss_addr;
   logic [PC_BITS-1:0]                    iss_npc;
   rmis_pkg::word_type                    iss_read_value;
   logic                                  mem_rd_en;
   logic [MEM_ADDR_BITS-1:0]              mem_rd_addr;
   rmis_pkg::word_type                    mem_rd_data;
   logic                                  mem_wr_en;
   logic [MEM_ADDR_BITS-1:0]              mem_wr_addr;
   rmis_pkg::word_type                    mem_wr_data;

   assign csr_hit = csr_paddr[rmis_pkg::CSR_ADDR_BITS-1] == rmis_pkg::CSR_IDX_PROGRAM_LENGTH;

   always_comb begin
      plen_in = plen_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         plen_in = csr_pwdata[rmis_pkg::PLEN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff <= rmis_pkg::PLEN_RESET;
      end else begin
         plen_ff <= plen_in;
      end
   end

   assign csr_prdata = csr_hit ? 32'(plen_ff) : '0;
   assign csr_pready = 1'b1;

   rmis_issue #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS),
      .PC_BITS       (PC_BITS)
   ) u_issue (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .mem_busy       (mem_busy),
      .pc             (pc),
      .program_length (plen_ff),
      .rd_r0          (rd_r0),
      .rd_rx          (rd_rx),
      .rd_idx         (rd_idx),
      .iss_done       (iss_done),
      .iss_valid      (iss_valid),
      .iss_ctl        (iss_ctl),
      .iss_addr       (iss_addr),
      .iss_npc        (iss_npc),
      .iss_read_value (iss_read_value),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr)
   );

   rmis_dmem #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_dmem (
      .clock   (clock),
      .reset   (reset),
      .busy    (mem_busy),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   rmis_exec #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS),
      .PC_BITS       (PC_BITS)
   ) u_exec (
      .clock          (clock),
      .reset          (reset),
      .iss_valid      (iss_valid),
      .iss_ctl        (iss_ctl),
      .iss_addr       (iss_addr),
      .iss_npc        (iss_npc),
      .iss_read_value (iss_read_value),
      .iss_done       (iss_done),
      .mem_rd_data    (mem_rd_data),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .rd_idx         (rd_idx),
      .rd_r0          (rd_r0),
      .rd_rx          (rd_rx),
      .pc             (pc),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

endmodule

`default_nettype wire

### hw/rtl/rmis_checker.sv
// ----------------------------------------------------------------------------
// rmis_checker
// Port-level checks of the instruction step, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rmis_checker (
   input wire                                  clock,
   input wire                                  reset,
   input wire                                  req_valid,
   input wire                                  req_stall,
   input wire                                  rsp_valid,
   input wire                                  rsp_stall,
   input rmis_pkg::rsp_type                    rsp_payload
);

   `RMIS_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   `RMIS_ASSERT_NEXT(a_rsp_payload_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))

   `RMIS_ASSERT_NEXT(a_issue_interlock, clock, reset, req_valid && !req_stall, req_stall)

   `RMIS_ASSERT_IMPL(a_rsp_after_issue, clock, reset, $rose(rsp_valid), $past(req_stall))

   `RMIS_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_payload.status <= rmis_pkg::ST_BAD_OP)

endmodule

bind register_machine_instruction_step rmis_checker u_rmis_checker (.*);

`default_nettype wire
